// ----- rtl/oahi_pkg.sv -----
// Shared types and constants for the open-addressing hash insert block.
package oahi_pkg;

  localparam int KEY_W       = 34;
  localparam int METHOD_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int DIGIT_W     = 4;
  localparam int DIGITS      = (KEY_W + DIGIT_W - 1) / DIGIT_W;
  localparam int KEY_PAD_W   = DIGITS * DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(DIGITS);
  localparam int S_TDATA_W   = ((KEY_W + METHOD_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((STATUS_W + SLOT_W + COUNT_W + 7) / 8) * 8;
  localparam int DBL_BASE    = 7;
  localparam int R7_W        = 3;

  typedef enum logic [METHOD_W-1:0] {
    PM_LINEAR    = 2'd0,
    PM_QUADRATIC = 2'd1,
    PM_DOUBLE    = 2'd2,
    PM_INVALID   = 2'd3
  } method_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED   = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_METHOD = 2'd2
  } status_e;

  typedef struct packed {
    logic    load;
    logic    advance;
    method_e method;
  } probe_ctrl_t;

  // One radix-16 step of the running remainder modulo 7.
  function automatic logic [R7_W-1:0] mod7_step(input logic [R7_W-1:0] rem,
                                               input logic [DIGIT_W-1:0] digit);
    logic [R7_W+DIGIT_W-1:0] v;
    v = {rem, digit};
    for (int k = 3; k >= 0; k--) begin
      if (v >= (R7_W + DIGIT_W)'(DBL_BASE << k)) begin
        v = v - (R7_W + DIGIT_W)'(DBL_BASE << k);
      end
    end
    return v[R7_W-1:0];
  endfunction

endpackage

// ----- rtl/oahi_hash.sv -----
// Digit-serial remainder unit: key mod table size and key mod 7.
module oahi_hash #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [oahi_pkg::KEY_W-1:0]     key_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_SIZE)-1:0]  home_o,
  output logic [oahi_pkg::R7_W-1:0]      r7_o
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int RW = IW + oahi_pkg::DIGIT_W;

  logic [oahi_pkg::KEY_PAD_W-1:0]   sh_q;
  logic [IW-1:0]                    rn_q, rn_d;
  logic [oahi_pkg::R7_W-1:0]        r7_q;
  logic [oahi_pkg::DIGIT_CNT_W-1:0] cnt_q;
  logic                             busy_q, done_q;
  logic [oahi_pkg::DIGIT_W-1:0]     digit;
  logic [RW-1:0]                    rn_v;

  assign digit = sh_q[oahi_pkg::KEY_PAD_W-1 -: oahi_pkg::DIGIT_W];

  always_comb begin
    rn_v = {rn_q, digit};
    for (int k = 3; k >= 0; k--) begin
      if (rn_v >= RW'(TABLE_SIZE << k)) begin
        rn_v = rn_v - RW'(TABLE_SIZE << k);
      end
    end
    rn_d = rn_v[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q   <= '0;
      rn_q   <= '0;
      r7_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        sh_q   <= oahi_pkg::KEY_PAD_W'(key_i);
        rn_q   <= '0;
        r7_q   <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        sh_q  <= sh_q << oahi_pkg::DIGIT_W;
        rn_q  <= rn_d;
        r7_q  <= oahi_pkg::mod7_step(r7_q, digit);
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == oahi_pkg::DIGIT_CNT_W'(oahi_pkg::DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign home_o = rn_q;
  assign r7_o   = r7_q;

endmodule

// ----- rtl/oahi_probe_gen.sv -----
// Probe slot sequencer: steps the candidate slot with a modular adder.
module oahi_probe_gen #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  oahi_pkg::probe_ctrl_t          ctrl_i,
  input  logic [$clog2(TABLE_SIZE)-1:0]  home_i,
  input  logic [oahi_pkg::R7_W-1:0]      r7_i,
  output logic [$clog2(TABLE_SIZE)-1:0]  slot_o
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int SW = IW + 1;
  localparam int CW = SW + oahi_pkg::R7_W;

  logic [IW-1:0] slot_q, inc_q;
  logic [IW-1:0] slot_d, inc_d, step_n;
  logic [SW-1:0] slot_sum, inc_sum;
  logic [CW-1:0] step_v;

  always_comb begin
    slot_sum = {1'b0, slot_q} + {1'b0, inc_q};
    if (slot_sum >= SW'(TABLE_SIZE)) begin
      slot_sum = slot_sum - SW'(TABLE_SIZE);
    end
    slot_d = slot_sum[IW-1:0];

    inc_sum = {1'b0, inc_q} + SW'(2);
    if (inc_sum >= SW'(TABLE_SIZE)) begin
      inc_sum = inc_sum - SW'(TABLE_SIZE);
    end
    inc_d = inc_sum[IW-1:0];

    step_v = CW'(oahi_pkg::R7_W'(oahi_pkg::DBL_BASE) - r7_i);
    for (int k = 0; k < 3; k++) begin
      if (step_v >= CW'(TABLE_SIZE)) begin
        step_v = step_v - CW'(TABLE_SIZE);
      end
    end
    step_n = step_v[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      inc_q  <= '0;
    end else if (ctrl_i.load) begin
      slot_q <= home_i;
      case (ctrl_i.method)
        oahi_pkg::PM_DOUBLE: inc_q <= step_n;
        default:             inc_q <= IW'(1);
      endcase
    end else if (ctrl_i.advance) begin
      slot_q <= slot_d;
      case (ctrl_i.method)
        oahi_pkg::PM_QUADRATIC: inc_q <= inc_d;
        default:                inc_q <= inc_q;
      endcase
    end
  end

  assign slot_o = slot_q;

endmodule

// ----- rtl/open_addressing_hash_insert.sv -----
// Top level of the open-addressing hash insert block.
// An accepted word runs through the radix-16 remainder unit, then one probe per
// cycle until a slot is found or all TABLE_SIZE probes hit occupied slots; an
// invalid method goes straight to the result. One word in flight at a time.
// Reset: asynchronous, active low; every slot marked empty, sequencer idle.
module open_addressing_hash_insert #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [33:0] key_value, [35:34] probe_method
  input  logic [oahi_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] status, [7:2] slot_index, [14:8] probe_count
  output logic [oahi_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CNT_W = IW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_OUT
  } state_e;

  state_e                        state_q;
  logic [oahi_pkg::KEY_W-1:0]    key_q;
  oahi_pkg::method_e             method_q;
  logic [CNT_W-1:0]              cnt_q;
  oahi_pkg::status_e             res_status_q;
  logic [IW-1:0]                 res_slot_q;
  logic [CNT_W-1:0]              res_count_q;
  logic [TABLE_SIZE-1:0]         valid_q;
  logic [oahi_pkg::KEY_W-1:0]    key_mem [TABLE_SIZE];

  logic [oahi_pkg::KEY_W-1:0]    in_key;
  oahi_pkg::method_e             in_method;
  logic                          hash_start, hash_done;
  logic [IW-1:0]                 home;
  logic [oahi_pkg::R7_W-1:0]     r7;
  logic [IW-1:0]                 slot;
  logic                          slot_busy, last_probe, wr_en;
  oahi_pkg::probe_ctrl_t         probe_ctrl;

  assign in_key    = s_axis_tdata[oahi_pkg::KEY_W-1:0];
  assign in_method = oahi_pkg::method_e'(
                       s_axis_tdata[oahi_pkg::KEY_W +: oahi_pkg::METHOD_W]);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);

  assign hash_start = (state_q == S_IDLE) && s_axis_tvalid &&
                      (in_method != oahi_pkg::PM_INVALID);
  assign slot_busy  = valid_q[slot];
  assign last_probe = (cnt_q == CNT_W'(TABLE_SIZE - 1));
  assign wr_en      = (state_q == S_PROBE) && !slot_busy;

  assign probe_ctrl.load    = (state_q == S_HASH) && hash_done;
  assign probe_ctrl.advance = (state_q == S_PROBE) && slot_busy && !last_probe;
  assign probe_ctrl.method  = method_q;

  oahi_hash #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_start),
    .key_i  (in_key),
    .done_o (hash_done),
    .home_o (home),
    .r7_o   (r7)
  );

  oahi_probe_gen #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_probe_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (probe_ctrl),
    .home_i (home),
    .r7_i   (r7),
    .slot_o (slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      key_q        <= '0;
      method_q     <= oahi_pkg::PM_LINEAR;
      cnt_q        <= '0;
      res_status_q <= oahi_pkg::ST_INSERTED;
      res_slot_q   <= '0;
      res_count_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            key_q    <= in_key;
            method_q <= in_method;
            if (in_method == oahi_pkg::PM_INVALID) begin
              res_status_q <= oahi_pkg::ST_BAD_METHOD;
              res_slot_q   <= '0;
              res_count_q  <= '0;
              state_q      <= S_OUT;
            end else begin
              state_q <= S_HASH;
            end
          end
        end
        S_HASH: begin
          cnt_q <= '0;
          if (hash_done) begin
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!slot_busy) begin
            res_status_q <= oahi_pkg::ST_INSERTED;
            res_slot_q   <= slot;
            res_count_q  <= cnt_q;
            state_q      <= S_OUT;
          end else if (last_probe) begin
            res_status_q <= oahi_pkg::ST_FULL;
            res_slot_q   <= '0;
            res_count_q  <= CNT_W'(TABLE_SIZE);
            state_q      <= S_OUT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[slot] <= key_q;
    end
  end

  assign m_axis_tdata = oahi_pkg::M_TDATA_W'({
                          oahi_pkg::COUNT_W'(res_count_q),
                          oahi_pkg::SLOT_W'(res_slot_q),
                          res_status_q});

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted a word while busy");

  a_inserted_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_status_q == oahi_pkg::ST_INSERTED) |-> valid_q[res_slot_q])
    else $error("inserted slot not marked occupied");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_status_q == oahi_pkg::ST_FULL) |->
      (res_count_q == CNT_W'(TABLE_SIZE)))
    else $error("full result with wrong probe count");
`endif

endmodule

// ----- bench/oahi_insert_check.sv -----
// Watches both stream ports, predicts each insert result and compares it with the block output.
module oahi_insert_check
  import oahi_pkg::*;
#(
  parameter int TABLE_SIZE = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e              status;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   probes;
  } insert_answer_t;

  logic           slot_taken [TABLE_SIZE];
  insert_answer_t insert_answers [$];

  function automatic insert_answer_t predict_insert(input logic [KEY_W-1:0] key,
                                                    input method_e method);
    insert_answer_t   answer;
    longint unsigned  k;
    longint unsigned  home;
    longint unsigned  stride;
    longint unsigned  offset;
    longint unsigned  pos;
    answer = '{status: ST_BAD_METHOD, slot: '0, probes: '0};
    if (method == PM_INVALID) begin
      return answer;
    end
    k      = key;
    home   = k % TABLE_SIZE;
    stride = DBL_BASE - (k % DBL_BASE);
    for (int i = 0; i < TABLE_SIZE; i++) begin
      case (method)
        PM_LINEAR:    offset = i;
        PM_QUADRATIC: offset = i * i;
        default:      offset = i * stride;
      endcase
      pos = (home + offset) % TABLE_SIZE;
      if (!slot_taken[pos]) begin
        slot_taken[pos] = 1'b1;
        answer.status   = ST_INSERTED;
        answer.slot     = SLOT_W'(pos);
        answer.probes   = COUNT_W'(i);
        return answer;
      end
    end
    answer.status = ST_FULL;
    answer.probes = COUNT_W'(TABLE_SIZE);
    return answer;
  endfunction

  task automatic note_mismatch(input string what, input insert_answer_t want,
                               input insert_answer_t got);
    if (fail_count_o < 10) begin
      $display({"%0t: %s: expected status %0d slot %0d probes %0d, ",
                "got status %0d slot %0d probes %0d"},
               $realtime, what, want.status, want.slot, want.probes,
               got.status, got.slot, got.probes);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    insert_answer_t got;
    insert_answer_t want;
    if (!rst_ni) begin
      foreach (slot_taken[j]) slot_taken[j] = 1'b0;
      insert_answers.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.status = status_e'(m_tdata_i[STATUS_W-1:0]);
        got.slot   = m_tdata_i[STATUS_W +: SLOT_W];
        got.probes = m_tdata_i[STATUS_W + SLOT_W +: COUNT_W];
        if (insert_answers.size() == 0) begin
          want = '0;
          note_mismatch("unexpected word", want, got);
        end else begin
          want = insert_answers.pop_front();
          if (got !== want) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        insert_answers.push_back(predict_insert(s_tdata_i[KEY_W-1:0],
                                                method_e'(s_tdata_i[KEY_W +: METHOD_W])));
      end
      pending_o = insert_answers.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the hash insert testbench: clock, reset, stimulus, output backpressure and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import oahi_pkg::*;

  localparam int TABLE_SIZE   = 16;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_WORDS = 935;
  localparam int PAUSE_AT     = 400;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  int                   fail_count;
  int                   pending_words;
  int                   sent_words    = 0;

  open_addressing_hash_insert #(
    .TABLE_SIZE(TABLE_SIZE)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  oahi_insert_check #(
    .TABLE_SIZE(TABLE_SIZE)
  ) i_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending_words)
  );

  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_insert(input logic [KEY_W-1:0] key, input method_e method);
    int gap;
    gap = (((sent_words / 64) % 3) == 2) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - KEY_W - METHOD_W){1'b0}}, method, key};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sent_words++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    wait (pending_words == 0);
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, quiet stretches, one long hold-off.
  initial begin
    int got_words;
    int stall;
    got_words = 0;
    forever begin
      if (got_words == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else if (((got_words / 48) % 4) == 3) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 15);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      @(posedge clk_i);
      got_words++;
    end
  end

  initial begin
    logic [KEY_W-1:0] key;
    method_e          method;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_insert('0, PM_INVALID);
    send_insert(KEY_MAX, PM_INVALID);
    send_insert('0, PM_LINEAR);
    send_insert(KEY_W'(16), PM_LINEAR);
    send_insert(KEY_W'(32), PM_QUADRATIC);
    send_insert(KEY_W'(48), PM_QUADRATIC);
    // quadratic from home 0 only reaches four slots: full with slots still empty
    send_insert(KEY_W'(64), PM_QUADRATIC);
    send_insert(KEY_MAX, PM_LINEAR);
    send_insert(KEY_MAX, PM_DOUBLE);
    send_insert(KEY_W'(7), PM_DOUBLE);
    send_insert(KEY_W'(23), PM_DOUBLE);
    send_insert(KEY_W'(34'h2_AAAA_AAAA), PM_LINEAR);
    send_insert(KEY_W'(34'h1_5555_5555), PM_QUADRATIC);
    send_insert(KEY_W'(34'h2_0000_0000), PM_DOUBLE);
    wait_drained();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        key = {2'($urandom_range(0, 3)), 32'($urandom)};
      end else begin
        key = KEY_W'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 15) == 0) begin
        method = PM_INVALID;
      end else begin
        method = method_e'(METHOD_W'($urandom_range(0, 2)));
      end
      if (n == PAUSE_AT) begin
        wait_drained();
      end
      send_insert(key, method);
    end
    s_axis_tvalid <= 1'b0;

    @(negedge clk_i);
    wait (pending_words == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
